### src/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// shared widths, gesture codes and register indexes for the touch gesture
// classifier
// ----------------------------------------------------------------------------
package tgc_pkg;

    localparam int unsigned CoordW   = 12;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned HoldW    = 16;
    localparam int unsigned FingerW  = 2;
    localparam int unsigned GestureW = 4;
    localparam int unsigned MaskW    = 4;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;

    typedef logic [CoordW-1:0]   t_coord;
    typedef logic [GestureW-1:0] t_gesture;
    typedef logic [1:0]          t_dir;

    // gesture codes
    localparam t_gesture G_NONE       = 4'd0;
    localparam t_gesture G_TAP        = 4'd1;
    localparam t_gesture G_LONG       = 4'd2;
    localparam t_gesture G_SWIPE_BASE = 4'd3;
    localparam t_gesture G_DRAG_BASE  = 4'd7;
    localparam t_gesture G_PARTIAL    = 4'd11;

    // direction index: left, right, up, down
    localparam t_dir DIR_LEFT  = 2'd0;
    localparam t_dir DIR_RIGHT = 2'd1;
    localparam t_dir DIR_UP    = 2'd2;
    localparam t_dir DIR_DOWN  = 2'd3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_DRAG_THRESHOLD  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SWIPE_THRESHOLD = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_LONG_TOUCH_MS   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PARTIAL_ENABLE  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DRAG_LATCH_MASK = 3'd4;

    // reset values of the configuration registers
    localparam t_coord             RST_DRAG_THRESHOLD  = 12'd20;
    localparam t_coord             RST_SWIPE_THRESHOLD = 12'd50;
    localparam logic [HoldW-1:0]   RST_LONG_TOUCH_MS   = 16'd800;
    localparam logic               RST_PARTIAL_ENABLE  = 1'b1;
    localparam logic [MaskW-1:0]   RST_DRAG_LATCH_MASK = 4'd12;

    // dominant-axis direction, vertical wins a tie
    function automatic t_dir dir_of(input t_coord adx, input t_coord ady,
                                    input logic x_pos, input logic y_pos);
        t_dir d;
        if (adx > ady) begin
            d = x_pos ? DIR_LEFT : DIR_RIGHT;
        end else begin
            d = y_pos ? DIR_UP : DIR_DOWN;
        end
        return d;
    endfunction

    // magnitude of a - b for unsigned coordinates
    function automatic t_coord abs_diff(input t_coord a, input t_coord b);
        t_coord r;
        if (a > b) begin
            r = a - b;
        end else begin
            r = b - a;
        end
        return r;
    endfunction

endpackage

### src/touch_gesture_classifier.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// classifies touch-panel reports into tap, long press, swipe, drag and
// partial-update events, one result word per report word
// ----------------------------------------------------------------------------
//
// usage
//   input channel (i_in_valid / o_in_ready) carries one report word: finger
//   count, first-finger x/y and a millisecond timestamp. each report word
//   produces exactly one result word on the output channel
//   (o_out_valid / i_out_ready), gesture none included.
//   the config channel (i_cfg_valid / o_cfg_ready) writes one register per
//   word by index; o_cfg_ready is always high. write only while idle.
// pipeline and throughput
//   two stages: an input register, then the classify logic feeding the
//   result register, through which each report passes to the output.
//   one report per cycle is accepted sustained while results are taken;
//   the touch state updates as a report leaves the input register, so
//   back-to-back reports see each other's effects in order.
// reset
//   synchronous active-low i_rst_n clears both stage valids, the touch state
//   and loads the register defaults (drag 20, swipe 50, hold 800 ms,
//   partial update on, latch mask left/right off, up/down on).
// stall
//   a held result keeps its value; the input register still takes one more
//   report, then o_in_ready drops until the result word is taken.
//
module touch_gesture_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // report channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tgc_pkg::FingerW-1:0]   i_finger_count,
    input  logic [tgc_pkg::CoordW-1:0]    i_touch_x,
    input  logic [tgc_pkg::CoordW-1:0]    i_touch_y,
    input  logic [tgc_pkg::TimeW-1:0]     i_time_ms,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tgc_pkg::GestureW-1:0]  o_gesture,
    output logic [tgc_pkg::CoordW-1:0]    o_start_x,
    output logic [tgc_pkg::CoordW-1:0]    o_start_y,
    output logic [tgc_pkg::CoordW-1:0]    o_abs_dx,
    output logic [tgc_pkg::CoordW-1:0]    o_abs_dy,
    // config channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tgc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [tgc_pkg::CfgDataW-1:0]  i_cfg_data
);
    import tgc_pkg::*;

    // config registers
    t_coord             r_drag_thr;
    t_coord             r_swipe_thr;
    logic [HoldW-1:0]   r_long_ms;
    logic               r_partial_en;
    logic [MaskW-1:0]   r_latch_mask;

    // input stage
    logic               r_in_vld;
    logic               r_in_down;
    t_coord             r_in_x;
    t_coord             r_in_y;
    logic [TimeW-1:0]   r_in_time;

    // touch state
    logic               r_active;
    logic [TimeW-1:0]   r_start_time;
    t_coord             r_org_x;
    t_coord             r_org_y;
    t_coord             r_prev_x;
    t_coord             r_prev_y;
    logic               r_long_fired;
    logic               r_drag_latched;

    // result stage
    logic               r_out_vld;
    t_gesture           r_gesture;
    t_coord             r_start_x;
    t_coord             r_start_y;
    t_coord             r_adx;
    t_coord             r_ady;

    // classify next values
    logic               n_active;
    logic [TimeW-1:0]   n_start_time;
    t_coord             n_org_x;
    t_coord             n_org_y;
    t_coord             n_prev_x;
    t_coord             n_prev_y;
    logic               n_long_fired;
    logic               n_drag_latched;
    t_gesture           n_gesture;
    t_coord             n_adx;
    t_coord             n_ady;

    logic               advance;
    t_coord             adx;
    t_coord             ady;
    t_dir               dir;
    logic [TimeW-1:0]   held;

    // the input register moves into the result register when the latter is
    // empty or being drained this cycle
    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_cfg_ready = 1'b1;

    // displacement from origin to previous point, "left"/"up" mean positive
    assign adx  = abs_diff(r_prev_x, r_org_x);
    assign ady  = abs_diff(r_prev_y, r_org_y);
    assign dir  = dir_of(adx, ady, r_prev_x > r_org_x, r_prev_y > r_org_y);
    assign held = r_in_time - r_start_time;

    always_comb begin
        n_active       = r_active;
        n_start_time   = r_start_time;
        n_org_x        = r_org_x;
        n_org_y        = r_org_y;
        n_prev_x       = r_prev_x;
        n_prev_y       = r_prev_y;
        n_long_fired   = r_long_fired;
        n_drag_latched = r_drag_latched;
        n_gesture      = G_NONE;
        n_adx          = '0;
        n_ady          = '0;
        if (r_in_down) begin
            if (!r_active) begin
                // touch start
                n_active       = 1'b1;
                n_start_time   = r_in_time;
                n_long_fired   = 1'b0;
                n_drag_latched = 1'b0;
                n_org_x        = r_in_x;
                n_org_y        = r_in_y;
            end else if (adx > r_drag_thr || ady > r_drag_thr) begin
                n_gesture      = G_DRAG_BASE + {2'b00, dir};
                n_drag_latched = r_latch_mask[dir];
                n_adx          = adx;
                n_ady          = ady;
            end else if (!r_long_fired && held > {{(TimeW-HoldW){1'b0}}, r_long_ms}) begin
                n_long_fired = 1'b1;
                n_gesture    = G_LONG;
            end
            n_prev_x = r_in_x;
            n_prev_y = r_in_y;
        end else if (r_active) begin
            // release
            if (!r_long_fired && !r_drag_latched) begin
                if (adx > r_swipe_thr || ady > r_swipe_thr) begin
                    n_gesture = G_SWIPE_BASE + {2'b00, dir};
                end else begin
                    n_gesture = G_TAP;
                end
            end else if (r_drag_latched && r_partial_en) begin
                n_gesture = G_PARTIAL;
            end
            n_active = 1'b0;
        end
    end

    // control and touch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_active       <= 1'b0;
            r_start_time   <= '0;
            r_org_x        <= '0;
            r_org_y        <= '0;
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_long_fired   <= 1'b0;
            r_drag_latched <= 1'b0;
            r_drag_thr     <= RST_DRAG_THRESHOLD;
            r_swipe_thr    <= RST_SWIPE_THRESHOLD;
            r_long_ms      <= RST_LONG_TOUCH_MS;
            r_partial_en   <= RST_PARTIAL_ENABLE;
            r_latch_mask   <= RST_DRAG_LATCH_MASK;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (advance) begin
                r_active       <= n_active;
                r_start_time   <= n_start_time;
                r_org_x        <= n_org_x;
                r_org_y        <= n_org_y;
                r_prev_x       <= n_prev_x;
                r_prev_y       <= n_prev_y;
                r_long_fired   <= n_long_fired;
                r_drag_latched <= n_drag_latched;
            end
            // register writes; unknown indexes fall through
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_DRAG_THRESHOLD:  r_drag_thr   <= i_cfg_data[CoordW-1:0];
                    REG_SWIPE_THRESHOLD: r_swipe_thr  <= i_cfg_data[CoordW-1:0];
                    REG_LONG_TOUCH_MS:   r_long_ms    <= i_cfg_data[HoldW-1:0];
                    REG_PARTIAL_ENABLE:  r_partial_en <= i_cfg_data[0];
                    REG_DRAG_LATCH_MASK: r_latch_mask <= i_cfg_data[MaskW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_down <= (i_finger_count != '0);
            r_in_x    <= i_touch_x;
            r_in_y    <= i_touch_y;
            r_in_time <= i_time_ms;
        end
        if (advance) begin
            r_gesture <= n_gesture;
            r_start_x <= n_org_x;
            r_start_y <= n_org_y;
            r_adx     <= n_adx;
            r_ady     <= n_ady;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_gesture   = r_gesture;
    assign o_start_x   = r_start_x;
    assign o_start_y   = r_start_y;
    assign o_abs_dx    = r_adx;
    assign o_abs_dy    = r_ady;

endmodule
